// ----- rtl/core/utf8d_pkg.sv -----
// Package for the UTF-8 validating decoder: request payload types, byte
// range constants and the lead-byte decode function.
// No dependencies.
`default_nettype none

package utf8d_pkg;

    // Byte range limits
    localparam logic [7:0] ASCII_END     = 8'h80;  // first non-ASCII byte
    localparam logic [7:0] BAD_LEAD_MAX  = 8'hC1;  // 80..C1 never lead
    localparam logic [7:0] LEAD3_MIN     = 8'hE0;
    localparam logic [7:0] LEAD4_MIN     = 8'hF0;
    localparam logic [7:0] BAD_LEAD_MIN  = 8'hF5;  // F5..FF never lead
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] CONT_MIN      = 8'h80;
    localparam logic [7:0] CONT_MAX      = 8'hBF;
    localparam logic [7:0] CONT_E0_MIN   = 8'hA0;
    localparam logic [7:0] CONT_ED_MAX   = 8'h9F;
    localparam logic [7:0] CONT_F0_MIN   = 8'h90;
    localparam logic [7:0] CONT_F4_MAX   = 8'h8F;

    // Scalar value limits
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_MIN     = 21'h00D800;
    localparam logic [20:0] SURR_MAX     = 21'h00DFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_req_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        is_valid;
        logic [2:0]  byte_count;
        logic        run_last;
        logic        string_last;
    } out_req_t;

    // Outcome of treating a byte as the start of a new sequence
    typedef struct packed {
        logic        emit;
        out_req_t    res;
        logic [1:0]  pend;
        logic [2:0]  exp_len;
        logic [20:0] pval;
        logic [7:0]  lead;
    } start_t;

    function automatic start_t start_decode(logic [7:0] b);
        start_t r;
        r = '0;
        if (b < ASCII_END) begin
            r.emit             = 1'b1;
            r.res.code_point   = {13'b0, b};
            r.res.is_valid     = 1'b1;
            r.res.byte_count   = 3'd1;
        end else if (b <= BAD_LEAD_MAX || b >= BAD_LEAD_MIN) begin
            r.emit             = 1'b1;
            r.res.byte_count   = 3'd1;
        end else begin
            r.lead = b;
            r.pend = 2'd1;
            if (b < LEAD3_MIN) begin
                r.exp_len = 3'd2;
                r.pval    = {16'b0, b[4:0]};
            end else if (b < LEAD4_MIN) begin
                r.exp_len = 3'd3;
                r.pval    = {17'b0, b[3:0]};
            end else begin
                r.exp_len = 3'd4;
                r.pval    = {18'b0, b[2:0]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utf8_validating_decoder.sv -----
// UTF-8 validating decoder top level: sequence state, single-pass decode and
// a three-entry result queue.
// Depends on utf8d_pkg.
//
//  channel | ports                     | direction | carries
//  --------+---------------------------+-----------+---------------------------
//  input   | s_valid s_ready s_data    | in        | one byte + end-of-string
//  result  | m_valid m_ready m_data    | out       | code point / invalid span
//
// One byte is accepted per cycle while s_ready is high; results are queued.
// A byte that breaks a sequence and also yields its own result (ASCII, bad
// byte, or a new lead flushed at end of string) makes two results.
// s_ready is high while at most one result is queued; even with one result
// taken per cycle, a two-result byte pulls s_ready low.
// Reset (aresetn low, synchronous) empties the queue and clears the sequence.
`default_nettype none

module utf8_validating_decoder (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  utf8d_pkg::in_req_t      s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output utf8d_pkg::out_req_t     m_data
);
    import utf8d_pkg::*;

    // Sequence state
    logic [1:0]  pend_reg,  pend_next;
    logic [2:0]  exp_reg,   exp_next;
    logic [20:0] pval_reg,  pval_next;
    logic [7:0]  lead_reg,  lead_next;

    // Result queue, head at entry 0
    out_req_t    q_reg [3];
    out_req_t    q_next [3];
    logic [1:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        pop;
    logic [1:0]  base;

    // Decode intermediates
    out_req_t    res [2];
    logic [1:0]  n_res;
    start_t      sd;
    logic        cont_ok;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [2:0]  pend_inc;
    logic [20:0] pval_ext;
    out_req_t    r_tmp;

    assign s_ready = (cnt_reg <= 2'd1);
    assign accept  = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q_reg[0];
    assign pop     = m_valid && m_ready;

    // Single-pass byte decode
    always_comb begin
        res[0]    = '0;
        res[1]    = '0;
        n_res     = 2'd0;
        r_tmp     = '0;
        pend_next = pend_reg;
        exp_next  = exp_reg;
        pval_next = pval_reg;
        lead_next = lead_reg;
        sd        = start_decode(s_data.in_byte);
        pend_inc  = {1'b0, pend_reg} + 3'd1;
        pval_ext  = {pval_reg[14:0], s_data.in_byte[5:0]};

        // Allowed continuation range; the second byte is narrowed by some leads
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (pend_reg == 2'd1) begin
            if (lead_reg == LEAD_E0) begin
                lo = CONT_E0_MIN;
            end else if (lead_reg == LEAD_ED) begin
                hi = CONT_ED_MAX;
            end else if (lead_reg == LEAD_F0) begin
                lo = CONT_F0_MIN;
            end else if (lead_reg == LEAD_F4) begin
                hi = CONT_F4_MAX;
            end
        end
        cont_ok = (s_data.in_byte >= lo) && (s_data.in_byte <= hi);

        if (pend_reg == 2'd0) begin
            // Idle: fresh start
            if (sd.emit) begin
                res[0] = sd.res;
                n_res  = 2'd1;
            end
            pend_next = sd.pend;
            exp_next  = sd.exp_len;
            pval_next = sd.pval;
            lead_next = sd.lead;
        end else if (cont_ok) begin
            // Gather continuation, emit when complete
            if (pend_inc == exp_reg) begin
                r_tmp.code_point = pval_ext;
                r_tmp.is_valid   = 1'b1;
                r_tmp.byte_count = exp_reg;
                res[0]    = r_tmp;
                n_res     = 2'd1;
                pend_next = 2'd0;
                exp_next  = 3'd0;
                pval_next = '0;
                lead_next = '0;
            end else begin
                pend_next = pend_inc[1:0];
                pval_next = pval_ext;
            end
        end else begin
            // Broken sequence: flush prefix, then restart on this byte
            r_tmp.byte_count = {1'b0, pend_reg};
            res[0] = r_tmp;
            n_res  = 2'd1;
            if (sd.emit) begin
                res[1] = sd.res;
                n_res  = 2'd2;
            end
            pend_next = sd.pend;
            exp_next  = sd.exp_len;
            pval_next = sd.pval;
            lead_next = sd.lead;
        end

        // End of string flushes any held prefix
        if (s_data.end_of_string && pend_next != 2'd0) begin
            r_tmp            = '0;
            r_tmp.byte_count = {1'b0, pend_next};
            res[n_res[0]]    = r_tmp;
            n_res            = n_res + 2'd1;
            pend_next        = 2'd0;
            exp_next         = 3'd0;
            pval_next        = '0;
            lead_next        = '0;
        end

        // Tag the last result of this byte
        if (n_res == 2'd2) begin
            res[1].run_last    = 1'b1;
            res[1].string_last = s_data.end_of_string;
        end else if (n_res == 2'd1) begin
            res[0].run_last    = 1'b1;
            res[0].string_last = s_data.end_of_string;
        end
    end

    // Queue update: shift on pop, append new results behind survivors
    always_comb begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        base     = cnt_reg - {1'b0, pop};
        cnt_next = base;
        if (accept) begin
            if (n_res != 2'd0) begin
                q_next[base] = res[0];
            end
            if (n_res == 2'd2) begin
                q_next[base + 2'd1] = res[1];
            end
            cnt_next = base + n_res;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            pend_reg <= 2'd0;
            exp_reg  <= 3'd0;
            pval_reg <= '0;
            lead_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept) begin
                pend_reg <= pend_next;
                exp_reg  <= exp_next;
                pval_reg <= pval_next;
                lead_reg <= lead_next;
            end
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

`ifndef ASSERT_OFF
    // A held prefix is always shorter than its expected length
    a_pend_lt_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd0) |-> ({1'b0, pend_reg} < exp_reg))
        else $error("held prefix not shorter than expected length");

    // End of string leaves no partial sequence behind
    a_eos_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_string) |=> (pend_reg == 2'd0))
        else $error("partial sequence survived end of string");

    // Invalid spans carry a zero code point
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_valid) |-> (m_data.code_point == '0))
        else $error("invalid span with nonzero code point");

    // Valid results are scalar values
    a_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_valid) |-> ((m_data.code_point <= CP_MAX) &&
        ((m_data.code_point < SURR_MIN) || (m_data.code_point > SURR_MAX))))
        else $error("decoded value is not a scalar value");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/utf8_decode_checker.sv -----
// Result checker for utf8_validating_decoder: watches both channels, decodes
// every accepted request byte on its own and compares the results in order.
// Depends on utf8d_pkg.
module utf8_decode_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  utf8d_pkg::in_req_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  utf8d_pkg::out_req_t  m_data,
    output int                   mismatch_count,
    output int                   pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    // Sequence being gathered
    logic [1:0]  held_bytes;
    logic [2:0]  seq_len;
    logic [20:0] seq_bits;
    logic [7:0]  seq_lead;

    // Results of the byte under decode, then the queue of expected results
    out_req_t    byte_results[2];
    int          byte_result_cnt;
    out_req_t    expected_chars[$];

    task automatic add_result(input logic [20:0] cp, input logic ok, input logic [2:0] cnt);
        out_req_t r;
        r = '0;
        r.code_point = cp;
        r.is_valid   = ok;
        r.byte_count = cnt;
        if (byte_result_cnt < 2) begin
            byte_results[byte_result_cnt] = r;
            byte_result_cnt++;
        end
    endtask

    task automatic drop_sequence();
        held_bytes = '0;
        seq_len    = '0;
        seq_bits   = '0;
        seq_lead   = '0;
    endtask

    // A byte seen with nothing held: ASCII, a bad lead, or a new sequence
    task automatic open_sequence(input logic [7:0] b);
        if (b < ASCII_END) begin
            add_result({13'b0, b}, 1'b1, 3'd1);
        end else if (b <= BAD_LEAD_MAX || b >= BAD_LEAD_MIN) begin
            add_result('0, 1'b0, 3'd1);
        end else begin
            seq_lead   = b;
            held_bytes = 2'd1;
            if (b < LEAD3_MIN) begin
                seq_len  = 3'd2;
                seq_bits = {16'b0, b[4:0]};
            end else if (b < LEAD4_MIN) begin
                seq_len  = 3'd3;
                seq_bits = {17'b0, b[3:0]};
            end else begin
                seq_len  = 3'd4;
                seq_bits = {18'b0, b[2:0]};
            end
        end
    endtask

    // Second byte has a narrowed range after E0, ED, F0 and F4
    function automatic logic fits_sequence(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (held_bytes == 2'd1) begin
            case (seq_lead)
                LEAD_E0: lo = CONT_E0_MIN;
                LEAD_ED: hi = CONT_ED_MAX;
                LEAD_F0: lo = CONT_F0_MIN;
                LEAD_F4: hi = CONT_F4_MAX;
                default: ;
            endcase
        end
        return b >= lo && b <= hi;
    endfunction

    task automatic decode_byte(input in_req_t req);
        logic [7:0] b;
        b = req.in_byte;
        byte_result_cnt = 0;
        if (held_bytes == 2'd0) begin
            open_sequence(b);
        end else if (fits_sequence(b)) begin
            seq_bits   = {seq_bits[14:0], b[5:0]};
            held_bytes = held_bytes + 2'd1;
            if (held_bytes == 2'd0 || {1'b0, held_bytes} >= seq_len) begin
                add_result(seq_bits, 1'b1, seq_len);
                drop_sequence();
            end
        end else begin
            // broken prefix goes out as one span, the byte starts afresh
            add_result('0, 1'b0, {1'b0, held_bytes});
            drop_sequence();
            open_sequence(b);
        end
        // end of string flushes whatever is still held
        if (req.end_of_string && held_bytes != 2'd0) begin
            add_result('0, 1'b0, {1'b0, held_bytes});
            drop_sequence();
        end
        if (byte_result_cnt > 0) begin
            byte_results[byte_result_cnt-1].run_last    = 1'b1;
            byte_results[byte_result_cnt-1].string_last = req.end_of_string;
        end
        for (int i = 0; i < byte_result_cnt; i++) expected_chars = {expected_chars, byte_results[i]};
    endtask

    task automatic report(input string fld, input int want, input int got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
        mismatch_count++;
    endtask

    // Predict on accepted requests, then compare accepted results
    always @(posedge aclk) begin
        out_req_t want;
        if (!aresetn) begin
            mismatch_count = 0;
            drop_sequence();
            expected_chars.delete();
        end else begin
            if (s_valid && s_ready) decode_byte(s_data);
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p", $time, m_data);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.code_point !== want.code_point)
                        report("code_point", want.code_point, m_data.code_point);
                    if (m_data.is_valid !== want.is_valid)
                        report("is_valid", want.is_valid, m_data.is_valid);
                    if (m_data.byte_count !== want.byte_count)
                        report("byte_count", want.byte_count, m_data.byte_count);
                    if (m_data.run_last !== want.run_last)
                        report("run_last", want.run_last, m_data.run_last);
                    if (m_data.string_last !== want.string_last)
                        report("string_last", want.string_last, m_data.string_last);
                end
            end
        end
        pending_results <= expected_chars.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for utf8_validating_decoder: clock, reset, byte stream
// stimulus with random idling and the final verdict.
// Depends on utf8d_pkg, utf8_validating_decoder and utf8_decode_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int RANDOM_BYTES = 1200;
    localparam int CALM_FROM    = 1000;  // no idling for strings begun from here on

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_req_t   s_data;
    logic      m_valid;
    logic      m_ready;
    out_req_t  m_data;

    int        mismatch_count;
    int        pending_results;
    logic      byte_taken = 1'b0;
    bit        in_idle_on = 1'b0;
    bit        out_stall_on = 1'b0;
    int        sent_bytes = 0;

    logic [7:0] text_bytes[$];
    logic [7:0] char_bytes[$];

    // Directed bytes, {eos, byte}
    logic [8:0] directed_bytes[] = '{
        9'h000, 9'h07F,                  // ASCII extremes
        9'h080, 9'h0C0, 9'h1FF,          // stray continuation, bad leads
        9'h0C2, 9'h080,                  // smallest two-byte
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // U+10FFFF
        9'h0E0, 9'h09F,                  // overlong three-byte second byte
        9'h0ED, 9'h0A0,                  // surrogate second byte
        9'h0F0, 9'h090, 9'h080, 9'h141,  // three held, broken by ASCII at eos
        9'h0F4, 9'h090,                  // above U+10FFFF
        9'h0E1, 9'h180,                  // incomplete at end of string
        9'h1F5                           // bad lead at end of string
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf8_validating_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_decode_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Request handshake seen at the rising edge, read by the driver at the falling one
    always @(posedge aclk) begin
        byte_taken <= s_valid && s_ready;
    end

    // Result side stalls in bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (out_stall_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, end_of_string: eos};
        do @(negedge aclk); while (!byte_taken);
        sent_bytes++;
    endtask

    // Append one byte to the character under construction
    task automatic add_char_byte(input logic [7:0] v);
        char_bytes = {char_bytes, v};
    endtask

    // One well-formed character of the given length into char_bytes
    task automatic make_char(input int len);
        logic [7:0] lead;
        char_bytes.delete();
        case (len)
            1: add_char_byte(8'($urandom_range(0, 8'h7F)));
            2: begin
                add_char_byte(8'($urandom_range(8'hC2, 8'hDF)));
                add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
            3: begin
                lead = 8'($urandom_range(LEAD3_MIN, 8'hEF));
                add_char_byte(lead);
                if (lead == LEAD_E0)
                    add_char_byte(8'($urandom_range(CONT_E0_MIN, CONT_MAX)));
                else if (lead == LEAD_ED)
                    add_char_byte(8'($urandom_range(CONT_MIN, CONT_ED_MAX)));
                else
                    add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
                add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
            default: begin
                lead = 8'($urandom_range(LEAD4_MIN, LEAD_F4));
                add_char_byte(lead);
                if (lead == LEAD_F0)
                    add_char_byte(8'($urandom_range(CONT_F0_MIN, CONT_MAX)));
                else if (lead == LEAD_F4)
                    add_char_byte(8'($urandom_range(CONT_MIN, CONT_F4_MAX)));
                else
                    add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
                add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
                add_char_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
        endcase
    endtask

    // Mostly well-formed text, some truncated or corrupted characters, some noise
    task automatic build_string();
        int pick;
        int len;
        text_bytes.delete();
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 99);
            len  = (pick < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            make_char(len);
            if (pick >= 90) begin
                char_bytes.delete();
                add_char_byte(8'($urandom_range(0, 255)));
            end else if (pick >= 80) begin
                char_bytes[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
            end else if (pick >= 70) begin
                repeat ($urandom_range(1, len - 1)) void'(char_bytes.pop_back());
            end
            text_bytes = {text_bytes, char_bytes};
        end
    endtask

    // Stimulus and verdict
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        while (sent_bytes < RANDOM_BYTES) begin
            // switch idling on and off now and then, none near the end
            if (sent_bytes >= CALM_FROM) begin
                in_idle_on   = 1'b0;
                out_stall_on = 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                in_idle_on   = $urandom_range(0, 2) != 0;
                out_stall_on = $urandom_range(0, 2) != 0;
            end
            build_string();
            foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        s_valid <= 1'b0;

        while (pending_results != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("utf8_validating_decoder regression: pass");
        end else begin
            $display("utf8_validating_decoder regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("utf8_validating_decoder regression: fail");
        $finish;
    end

endmodule

// ----- utf8_validating_decoder.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8_validating_decoder.sv
tb/sv/utf8_decode_checker.sv
tb/sv/tb_top.sv
